// ===== hdl/rfa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfa_pkg
// Shared constants, codes and command/status types for the fraction ALU.
// ----------------------------------------------------------------------------
package rfa_pkg;

    localparam int unsigned DefWidth = 32;
    localparam int unsigned MagW     = 64;

    localparam logic [1:0] FUNC_ADD = 2'd0;
    localparam logic [1:0] FUNC_SUB = 2'd1;
    localparam logic [1:0] FUNC_MUL = 2'd2;
    localparam logic [1:0] FUNC_DIV = 2'd3;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_MUL1,
        CMD_MUL2,
        CMD_MUL3,
        CMD_COMBINE,
        CMD_GINIT,
        CMD_DIVINIT,
        CMD_DIVSTEP,
        CMD_DIVSWAP,
        CMD_FINISH,
        CMD_UNDEF,
        CMD_ZERO
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [1:0] divsel;
    } t_ctl;

    typedef struct packed {
        logic early;
        logic div_last;
        logic gcd_done;
        logic num_zero;
    } t_sts;

    localparam logic [1:0] DSEL_GCD = 2'd0;
    localparam logic [1:0] DSEL_NUM = 2'd1;
    localparam logic [1:0] DSEL_DEN = 2'd2;

endpackage

// ===== hdl/rfa_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfa_datapath
// Sign/magnitude split, shared 32x32 multiplier, bit-serial 64-bit divider
// used both for the Euclidean gcd and the final reduction, range check.
// ----------------------------------------------------------------------------
module rfa_datapath #(
    parameter int unsigned WIDTH = rfa_pkg::DefWidth
) (
    input  logic                 i_clk,
    input  rfa_pkg::t_ctl        i_ctl,
    input  logic [1:0]           i_func,
    input  logic [31:0]          i_a_num,
    input  logic [31:0]          i_a_den,
    input  logic [31:0]          i_b_num,
    input  logic [31:0]          i_b_den,
    output rfa_pkg::t_sts        o_sts,
    output logic [31:0]          o_res_num,
    output logic [30:0]          o_res_den,
    output logic                 o_undef,
    output logic                 o_ovf
);
    import rfa_pkg::*;

    localparam logic [MagW-1:0] Lim   = MagW'(1) << (WIDTH - 1);
    localparam logic [MagW-1:0] LimM1 = Lim - MagW'(1);

    logic [1:0]      r_op;
    logic [31:0]     r_an, r_ad, r_bn, r_bd;
    logic            r_san, r_sad, r_sbn, r_sbd;
    logic [MagW-1:0] r_p, r_q, r_dm, r_nm;
    logic            r_sp, r_sq, r_sn, r_sd;
    logic [MagW-1:0] r_x, r_y;
    logic [MagW-1:0] r_rem, r_quo, r_dvd;
    logic [5:0]      r_cnt;
    logic [MagW-1:0] r_nq;
    logic [31:0]     r_res_num;
    logic [30:0]     r_res_den;
    logic            r_undef, r_ovf;

    logic [31:0]     mul_a, mul_b;
    logic [MagW-1:0] mul_p;
    logic [MagW-1:0] divisor;
    logic [MagW:0]   sh_rem, trial;
    logic            neg;

    function automatic logic [31:0] mag32(input logic [31:0] v);
        mag32 = v[31] ? (32'd0 - v) : v;
    endfunction

    always_comb begin
        mul_a = r_an;
        mul_b = r_bd;
        if (i_ctl.cmd == CMD_MUL1) begin
            mul_b = (r_op == FUNC_MUL) ? r_bn : r_bd;
        end else if (i_ctl.cmd == CMD_MUL2) begin
            mul_a = r_ad;
            mul_b = (r_op == FUNC_DIV) ? r_bn : r_bd;
        end else if (i_ctl.cmd == CMD_MUL3) begin
            mul_a = r_bn;
            mul_b = r_ad;
        end
    end
    assign mul_p = MagW'(mul_a) * MagW'(mul_b);

    // gcd divides x by y; the reductions divide by the gcd left in x
    always_comb begin
        case (i_ctl.divsel)
            DSEL_GCD: divisor = r_y;
            default:  divisor = r_x;
        endcase
        sh_rem = {r_rem, r_dvd[MagW-1]};
        trial  = sh_rem - {1'b0, divisor};
    end

    assign neg = r_sn != r_sd;

    always_ff @(posedge i_clk) begin
        case (i_ctl.cmd)
            CMD_LOAD: begin
                r_op  <= i_func;
                r_an  <= mag32(i_a_num);
                r_ad  <= mag32(i_a_den);
                r_bn  <= mag32(i_b_num);
                r_bd  <= mag32(i_b_den);
                r_san <= i_a_num[31];
                r_sad <= i_a_den[31];
                r_sbn <= i_b_num[31];
                r_sbd <= i_b_den[31];
            end
            CMD_MUL1: begin
                r_p <= mul_p;
                if (r_op == FUNC_MUL) begin
                    r_sp <= r_san != r_sbn;
                end else begin
                    r_sp <= r_san != r_sbd;
                end
            end
            CMD_MUL2: begin
                r_dm <= mul_p;
                if (r_op == FUNC_DIV) begin
                    r_sd <= r_sad != r_sbn;
                end else begin
                    r_sd <= r_sad != r_sbd;
                end
                r_sq <= (r_sbn != r_sad) != (r_op == FUNC_SUB);
            end
            CMD_MUL3: begin
                r_q <= mul_p;
            end
            CMD_COMBINE: begin
                if (r_op[1]) begin
                    r_nm <= r_p;
                    r_sn <= r_sp;
                end else if (r_sp == r_sq) begin
                    r_nm <= r_p + r_q;
                    r_sn <= r_sp;
                end else if (r_p >= r_q) begin
                    r_nm <= r_p - r_q;
                    r_sn <= r_sp;
                end else begin
                    r_nm <= r_q - r_p;
                    r_sn <= r_sq;
                end
            end
            CMD_GINIT: begin
                r_x <= r_nm;
                r_y <= r_dm;
            end
            CMD_DIVINIT: begin
                case (i_ctl.divsel)
                    DSEL_GCD: r_dvd <= r_x;
                    DSEL_NUM: r_dvd <= r_nm;
                    default:  r_dvd <= r_dm;
                endcase
                r_rem <= '0;
                r_quo <= '0;
                r_cnt <= '0;
            end
            CMD_DIVSTEP: begin
                r_dvd <= {r_dvd[MagW-2:0], 1'b0};
                if (!trial[MagW]) begin
                    r_rem <= trial[MagW-1:0];
                    r_quo <= {r_quo[MagW-2:0], 1'b1};
                end else begin
                    r_rem <= sh_rem[MagW-1:0];
                    r_quo <= {r_quo[MagW-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 6'd1;
            end
            CMD_DIVSWAP: begin
                case (i_ctl.divsel)
                    DSEL_GCD: begin
                        r_x <= r_y;
                        r_y <= r_rem;
                    end
                    default: begin
                        // numerator quotient kept, denominator division set up
                        r_nq  <= r_quo;
                        r_dvd <= r_dm;
                        r_rem <= '0;
                        r_quo <= '0;
                        r_cnt <= '0;
                    end
                endcase
            end
            CMD_FINISH: begin
                if (r_quo > LimM1 || (neg ? r_nq > Lim : r_nq > LimM1)) begin
                    r_res_num <= '0;
                    r_res_den <= '0;
                    r_ovf     <= 1'b1;
                end else begin
                    r_res_num <= neg ? (32'd0 - r_nq[31:0]) : r_nq[31:0];
                    r_res_den <= r_quo[30:0];
                    r_ovf     <= 1'b0;
                end
                r_undef <= 1'b0;
            end
            CMD_UNDEF: begin
                r_res_num <= '0;
                r_res_den <= '0;
                r_undef   <= 1'b1;
                r_ovf     <= 1'b0;
            end
            CMD_ZERO: begin
                r_res_num <= '0;
                r_res_den <= 31'd1;
                r_undef   <= 1'b0;
                r_ovf     <= 1'b0;
            end
            default: begin
            end
        endcase
    end

    assign o_sts.early    = r_ad == '0 || r_bd == '0 || (r_op == FUNC_DIV && r_bn == '0);
    assign o_sts.div_last = r_cnt == 6'd63;
    assign o_sts.gcd_done = r_y == '0;
    assign o_sts.num_zero = r_nm == '0;

    assign o_res_num = r_res_num;
    assign o_res_den = r_res_den;
    assign o_undef   = r_undef;
    assign o_ovf     = r_ovf;

endmodule

// ===== hdl/rfa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfa_ctrl
// Sequencer: load, three products, combine, gcd loop, two divisions, output.
// ----------------------------------------------------------------------------
module rfa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  rfa_pkg::t_sts i_sts,
    output rfa_pkg::t_ctl o_ctl
);
    import rfa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CHK, S_MUL1, S_MUL2, S_MUL3, S_COMB, S_ZCHK, S_GCHK,
        S_GDIV, S_GSWAP, S_NDIV, S_NSWAP, S_DDIV, S_FIN, S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid;
        o_ctl.cmd    = CMD_NONE;
        o_ctl.divsel = DSEL_GCD;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.cmd = CMD_LOAD;
                    n_state   = S_CHK;
                end
            end
            S_CHK: begin
                if (i_sts.early) begin
                    o_ctl.cmd   = CMD_UNDEF;
                    n_state     = S_OUT;
                    n_out_valid = 1'b1;
                end else begin
                    n_state = S_MUL1;
                end
            end
            S_MUL1: begin
                o_ctl.cmd = CMD_MUL1;
                n_state   = S_MUL2;
            end
            S_MUL2: begin
                o_ctl.cmd = CMD_MUL2;
                n_state   = S_MUL3;
            end
            S_MUL3: begin
                o_ctl.cmd = CMD_MUL3;
                n_state   = S_COMB;
            end
            S_COMB: begin
                o_ctl.cmd = CMD_COMBINE;
                n_state   = S_ZCHK;
            end
            S_ZCHK: begin
                if (i_sts.num_zero) begin
                    o_ctl.cmd   = CMD_ZERO;
                    n_state     = S_OUT;
                    n_out_valid = 1'b1;
                end else begin
                    o_ctl.cmd = CMD_GINIT;
                    n_state   = S_GCHK;
                end
            end
            S_GCHK: begin
                o_ctl.cmd = CMD_DIVINIT;
                if (i_sts.gcd_done) begin
                    o_ctl.divsel = DSEL_NUM;
                    n_state      = S_NDIV;
                end else begin
                    n_state = S_GDIV;
                end
            end
            S_GDIV: begin
                o_ctl.cmd = CMD_DIVSTEP;
                if (i_sts.div_last) begin
                    n_state = S_GSWAP;
                end
            end
            S_GSWAP: begin
                o_ctl.cmd = CMD_DIVSWAP;
                n_state   = S_GCHK;
            end
            S_NDIV: begin
                o_ctl.cmd    = CMD_DIVSTEP;
                o_ctl.divsel = DSEL_NUM;
                if (i_sts.div_last) begin
                    n_state = S_NSWAP;
                end
            end
            S_NSWAP: begin
                o_ctl.cmd    = CMD_DIVSWAP;
                o_ctl.divsel = DSEL_NUM;
                n_state      = S_DDIV;
            end
            S_DDIV: begin
                o_ctl.cmd    = CMD_DIVSTEP;
                o_ctl.divsel = DSEL_DEN;
                if (i_sts.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_ctl.cmd   = CMD_FINISH;
                n_state     = S_OUT;
                n_out_valid = 1'b1;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;

endmodule

// ===== hdl/rational_fraction_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_fraction_alu
// Exact add/sub/mul/div of two fractions with gcd reduction.
//
// channel | dir | tdata fields (low bit up)                  | tuser
// s_axis  | in  | func, a_num, a_den, b_num, b_den            | -
// m_axis  | out | res_num, res_den, is_undefined, overflow    | -
//
// One item at a time: operand check, three products, combine, zero check, gcd
// loop (Euclid steps, at most about 92, each a 64-step restoring divide), two
// reducing divides. Undefined operands exit at the operand check, a zero
// numerator at the zero check. A result waits in its register for m_axis_tready;
// input is ready again the cycle after. Synchronous active-low reset.
// ----------------------------------------------------------------------------
module rational_fraction_alu #(
    parameter int unsigned WIDTH = rfa_pkg::DefWidth
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // func[1:0], a_num[33:2], a_den[65:34], b_num[97:66], b_den[129:98]
    input  logic [135:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // res_num[31:0], res_den[62:32], is_undefined[63], overflow[64]
    output logic [71:0]  m_axis_tdata
);
    import rfa_pkg::*;

    t_ctl        ctl;
    t_sts        sts;
    logic [31:0] res_num;
    logic [30:0] res_den;
    logic        undef, ovf;

    rfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_ctl       (ctl)
    );

    rfa_datapath #(.WIDTH(WIDTH)) u_dp (
        .i_clk     (i_clk),
        .i_ctl     (ctl),
        .i_func    (s_axis_tdata[1:0]),
        .i_a_num   (s_axis_tdata[33:2]),
        .i_a_den   (s_axis_tdata[65:34]),
        .i_b_num   (s_axis_tdata[97:66]),
        .i_b_den   (s_axis_tdata[129:98]),
        .o_sts     (sts),
        .o_res_num (res_num),
        .o_res_den (res_den),
        .o_undef   (undef),
        .o_ovf     (ovf)
    );

    assign m_axis_tdata = {7'd0, ovf, undef, res_den, res_num};

endmodule
